/* rtl/core/triangle_tangent_generator_macros.svh */
// Assertion macros shared by the triangle tangent generator RTL.
`ifndef TRIANGLE_TANGENT_GENERATOR_MACROS_SVH
`define TRIANGLE_TANGENT_GENERATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TTG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tangent generator check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TTG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tangent generator check failed");

`endif

/* rtl/core/ttg_pkg.sv */
// Package with types and constants of the triangle tangent generator.
package ttg_pkg;

   localparam int COORD_W   = 24;
   localparam int UNIT_W    = 16;
   localparam int UNIT_F    = UNIT_W - 2;
   localparam int DIFF_W    = 25;
   localparam int DIFF_DROP = (COORD_W > 24) ? COORD_W - 24 : 0;
   localparam int ACC_W     = 52;
   localparam int MUL_W     = (UNIT_W + 3 > DIFF_W) ? UNIT_W + 3 : DIFF_W;
   localparam int RED_W     = 20;
   localparam int SUM_W     = 42;
   localparam int LEN_W     = 21;
   localparam int DIV_W     = UNIT_W + LEN_W;
   localparam int CNT_W     = $clog2(UNIT_W);
   localparam int DR_W      = UNIT_W + 3;

   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] tex_u;
      logic signed [COORD_W-1:0] tex_v;
      logic signed [UNIT_W-1:0]  norm_x;
      logic signed [UNIT_W-1:0]  norm_y;
      logic signed [UNIT_W-1:0]  norm_z;
      logic                      end_of_mesh;
   } req_type;

   typedef struct packed {
      logic signed [UNIT_W-1:0] tangent_x;
      logic signed [UNIT_W-1:0] tangent_y;
      logic signed [UNIT_W-1:0] tangent_z;
      logic                     degenerate;
      logic                     last_triangle;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DET0, ST_DET1, ST_CHK, ST_RAW0, ST_RAW1, ST_RAW2,
      ST_ABS, ST_RED, ST_SQ, ST_RTLD, ST_ROOT, ST_LEN, ST_DIVLD, ST_DIV,
      ST_DIVST, ST_DOT, ST_RND, ST_GS0, ST_GS1, ST_OUT
   } state_type;

   // Control of the shared multiply-accumulate unit.
   typedef struct packed {
      logic en;
      logic from_acc;
      logic from_base;
      logic sub;
   } mac_ctrl_type;

endpackage

/* rtl/core/ttg_mac.sv */
// Shared registered multiply-accumulate unit of the tangent generator.
module ttg_mac (
   input  logic                                 clock,
   input  ttg_pkg::mac_ctrl_type                ctrl,
   input  logic signed [ttg_pkg::MUL_W-1:0]     op_a,
   input  logic signed [ttg_pkg::MUL_W-1:0]     op_b,
   input  logic signed [ttg_pkg::ACC_W-1:0]     base,
   output logic signed [ttg_pkg::ACC_W-1:0]     acc
);
   import ttg_pkg::*;

   logic signed [2*MUL_W-1:0] prod;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   addend;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;

   // The addend is zero, the running sum or an outside base value.
   always_comb begin
      prod     = op_a * op_b;
      prod_ext = ACC_W'(prod);
      if (ctrl.from_acc) begin
         addend = acc_ff;
      end else if (ctrl.from_base) begin
         addend = base;
      end else begin
         addend = '0;
      end
      if (!ctrl.en) begin
         acc_in = acc_ff;
      end else if (ctrl.sub) begin
         acc_in = addend - prod_ext;
      end else begin
         acc_in = addend + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

/* rtl/core/triangle_tangent_generator.sv */
// Top level of the triangle tangent generator: vertex gathering and sequencer.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req (ttg_pkg::req_type)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp (ttg_pkg::rsp_type)
//
// The first two vertices of a triangle are only registered when taken.
// The third vertex starts the tangent computation, which ends early for a degenerate triangle:
// one shared multiply-accumulate unit does all products, the root takes 21 steps and
// each divide 16 steps, and the range reduction shifts one bit a cycle, twice per triangle.
// Reset is synchronous and active high; it clears the phase, sequencer and output valid.
// A stalled result holds in the output register; vertices that finish no triangle
// are still taken meanwhile.
module triangle_tangent_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ttg_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttg_pkg::rsp_type rsp
);
   import ttg_pkg::*;
`include "triangle_tangent_generator_macros.svh"

   function automatic logic signed [DIFF_W-1:0] fdiff(input logic signed [COORD_W-1:0] a,
                                                      input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      d = (COORD_W+1)'(a) - (COORD_W+1)'(b);
      return DIFF_W'(d >>> DIFF_DROP);
   endfunction

   state_type state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] ci_ff, ci_in;
   logic       pass_ff, pass_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept, load;

   logic signed [COORD_W-1:0] p0_ff [3], p0_in [3];
   logic signed [COORD_W-1:0] p1_ff [3], p1_in [3];
   logic signed [COORD_W-1:0] uv0_ff [2], uv0_in [2];
   logic signed [COORD_W-1:0] uv1_ff [2], uv1_in [2];
   logic signed [UNIT_W-1:0]  n_ff [3], n_in [3];
   logic signed [DIFF_W-1:0]  e1_ff [3], e1_in [3];
   logic signed [DIFF_W-1:0]  e2_ff [3], e2_in [3];
   logic signed [DIFF_W-1:0]  du1_ff, du1_in, dv1_ff, dv1_in;
   logic signed [DIFF_W-1:0]  du2_ff, du2_in, dv2_ff, dv2_in;
   logic signed [ACC_W-1:0]   vec_ff [3], vec_in [3];
   logic [ACC_W-1:0]          mag_ff [3], mag_in [3];
   logic                      neg_ff [3], neg_in [3];
   logic signed [UNIT_W-1:0]  t_ff [3], t_in [3];
   logic                      detneg_ff, detneg_in;
   logic                      last_ff, last_in;
   logic                      degen_ff, degen_in;
   logic [SUM_W-1:0]          sqv_ff, sqv_in, sqr_ff, sqr_in, sqb_ff, sqb_in;
   logic [SUM_W-1:0]          root_trial;
   logic [DIV_W-1:0]          rem_ff, rem_in, dsh_ff, dsh_in;
   logic [UNIT_W-1:0]         q_ff, q_in;
   logic [CNT_W-1:0]          j_ff, j_in;
   logic signed [DR_W-1:0]    dr_ff, dr_in;
   logic [ACC_W-1:0]          rnd_mag, rnd_q;
   logic                      any_big;
   rsp_type                   rsp_ff, rsp_in;

   mac_ctrl_type            mac_ctrl;
   logic signed [MUL_W-1:0] mac_a, mac_b;
   logic signed [ACC_W-1:0] mac_base, acc;

   ttg_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .base  (mac_base),
      .acc   (acc)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign load      = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // Shared helper values of the root, reduction and rounding steps.
   always_comb begin
      root_trial = sqr_ff + sqb_ff;
      any_big    = (|mag_ff[0][ACC_W-1:RED_W]) || (|mag_ff[1][ACC_W-1:RED_W]) ||
                   (|mag_ff[2][ACC_W-1:RED_W]);
      rnd_mag    = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      rnd_q      = (rnd_mag + (ACC_W'(1) << (UNIT_F - 1))) >> UNIT_F;
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && phase_ff == 2'd2) state_in = ST_DET0;
         ST_DET0:  state_in = ST_DET1;
         ST_DET1:  state_in = ST_CHK;
         ST_CHK:   state_in = (acc == '0) ? ST_OUT : ST_RAW0;
         ST_RAW0:  state_in = ST_RAW1;
         ST_RAW1:  state_in = ST_RAW2;
         ST_RAW2:  state_in = (ci_ff == 2'd2) ? ST_ABS : ST_RAW0;
         ST_ABS:   state_in = ST_RED;
         ST_RED:   state_in = any_big ? ST_RED : ST_SQ;
         ST_SQ:    state_in = (ci_ff == 2'd2) ? ST_RTLD : ST_SQ;
         ST_RTLD:  state_in = ST_ROOT;
         ST_ROOT:  state_in = sqb_ff[0] ? ST_LEN : ST_ROOT;
         ST_LEN:   state_in = (sqr_ff == '0) ? ST_OUT : ST_DIVLD;
         ST_DIVLD: state_in = ST_DIV;
         ST_DIV:   state_in = (j_ff == '0) ? ST_DIVST : ST_DIV;
         ST_DIVST: begin
            if (ci_ff != 2'd2) begin
               state_in = ST_DIVLD;
            end else begin
               state_in = pass_ff ? ST_OUT : ST_DOT;
            end
         end
         ST_DOT:   state_in = (ci_ff == 2'd2) ? ST_RND : ST_DOT;
         ST_RND:   state_in = ST_GS0;
         ST_GS0:   state_in = ST_GS1;
         ST_GS1:   state_in = (ci_ff == 2'd2) ? ST_ABS : ST_GS0;
         ST_OUT:   if (load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Datapath and multiply-accumulate control for each step.
   always_comb begin
      phase_in  = phase_ff;
      ci_in     = ci_ff;
      pass_in   = pass_ff;
      p0_in     = p0_ff;
      p1_in     = p1_ff;
      uv0_in    = uv0_ff;
      uv1_in    = uv1_ff;
      n_in      = n_ff;
      e1_in     = e1_ff;
      e2_in     = e2_ff;
      du1_in    = du1_ff;
      dv1_in    = dv1_ff;
      du2_in    = du2_ff;
      dv2_in    = dv2_ff;
      vec_in    = vec_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      t_in      = t_ff;
      detneg_in = detneg_ff;
      last_in   = last_ff;
      degen_in  = degen_ff;
      sqv_in    = sqv_ff;
      sqr_in    = sqr_ff;
      sqb_in    = sqb_ff;
      rem_in    = rem_ff;
      dsh_in    = dsh_ff;
      q_in      = q_ff;
      j_in      = j_ff;
      dr_in     = dr_ff;
      rsp_in    = rsp_ff;
      mac_ctrl  = '0;
      mac_a     = '0;
      mac_b     = '0;
      mac_base  = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (phase_ff == 2'd1) begin
                  p1_in[0]  = req.pos_x;
                  p1_in[1]  = req.pos_y;
                  p1_in[2]  = req.pos_z;
                  uv1_in[0] = req.tex_u;
                  uv1_in[1] = req.tex_v;
                  phase_in  = req.end_of_mesh ? 2'd0 : 2'd2;
               end else if (phase_ff == 2'd2) begin
                  e1_in[0] = fdiff(p1_ff[0], p0_ff[0]);
                  e1_in[1] = fdiff(p1_ff[1], p0_ff[1]);
                  e1_in[2] = fdiff(p1_ff[2], p0_ff[2]);
                  e2_in[0] = fdiff(req.pos_x, p0_ff[0]);
                  e2_in[1] = fdiff(req.pos_y, p0_ff[1]);
                  e2_in[2] = fdiff(req.pos_z, p0_ff[2]);
                  du1_in   = fdiff(uv1_ff[0], uv0_ff[0]);
                  dv1_in   = fdiff(uv1_ff[1], uv0_ff[1]);
                  du2_in   = fdiff(req.tex_u, uv0_ff[0]);
                  dv2_in   = fdiff(req.tex_v, uv0_ff[1]);
                  last_in  = req.end_of_mesh;
                  degen_in = 1'b0;
                  pass_in  = 1'b0;
                  phase_in = 2'd0;
               end else begin
                  p0_in[0]  = req.pos_x;
                  p0_in[1]  = req.pos_y;
                  p0_in[2]  = req.pos_z;
                  uv0_in[0] = req.tex_u;
                  uv0_in[1] = req.tex_v;
                  n_in[0]   = req.norm_x;
                  n_in[1]   = req.norm_y;
                  n_in[2]   = req.norm_z;
                  phase_in  = req.end_of_mesh ? 2'd0 : 2'd1;
               end
            end
         end
         ST_DET0: begin
            mac_ctrl.en = 1'b1;
            mac_a       = MUL_W'(du1_ff);
            mac_b       = MUL_W'(dv2_ff);
         end
         ST_DET1: begin
            mac_ctrl.en       = 1'b1;
            mac_ctrl.from_acc = 1'b1;
            mac_ctrl.sub      = 1'b1;
            mac_a             = MUL_W'(du2_ff);
            mac_b             = MUL_W'(dv1_ff);
         end
         ST_CHK: begin
            detneg_in = acc[ACC_W-1];
            degen_in  = (acc == '0);
            ci_in     = 2'd0;
         end
         ST_RAW0: begin
            mac_ctrl.en = 1'b1;
            mac_a       = MUL_W'(dv2_ff);
            mac_b       = MUL_W'(e1_ff[ci_ff]);
         end
         ST_RAW1: begin
            mac_ctrl.en       = 1'b1;
            mac_ctrl.from_acc = 1'b1;
            mac_ctrl.sub      = 1'b1;
            mac_a             = MUL_W'(dv1_ff);
            mac_b             = MUL_W'(e2_ff[ci_ff]);
         end
         ST_RAW2: begin
            vec_in[ci_ff] = detneg_ff ? -acc : acc;
            ci_in         = (ci_ff == 2'd2) ? 2'd0 : ci_ff + 2'd1;
         end
         // Magnitudes and signs of the vector to normalize.
         ST_ABS: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = vec_ff[i][ACC_W-1];
               mag_in[i] = vec_ff[i][ACC_W-1] ? ACC_W'(-vec_ff[i]) : ACC_W'(vec_ff[i]);
            end
         end
         // Range reduction: one bit of truncating shift a cycle.
         ST_RED: begin
            if (any_big) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
            end
            ci_in = 2'd0;
         end
         ST_SQ: begin
            mac_ctrl.en       = 1'b1;
            mac_ctrl.from_acc = (ci_ff != 2'd0);
            mac_a = MUL_W'($signed({1'b0, mag_ff[ci_ff][RED_W-1:0]}));
            mac_b = MUL_W'($signed({1'b0, mag_ff[ci_ff][RED_W-1:0]}));
            ci_in = (ci_ff == 2'd2) ? 2'd0 : ci_ff + 2'd1;
         end
         ST_RTLD: begin
            sqv_in = acc[SUM_W-1:0];
            sqr_in = '0;
            sqb_in = SUM_W'(1) << (SUM_W - 2);
         end
         // One step of the bitwise integer square root.
         ST_ROOT: begin
            if (sqv_ff >= root_trial) begin
               sqv_in = sqv_ff - root_trial;
               sqr_in = (sqr_ff >> 1) + sqb_ff;
            end else begin
               sqr_in = sqr_ff >> 1;
            end
            sqb_in = sqb_ff >> 2;
         end
         ST_LEN: begin
            degen_in = (sqr_ff == '0);
            ci_in    = 2'd0;
         end
         // Rounded quotient (mag * 2^(F+1) + len) / (2 * len), one bit a cycle.
         ST_DIVLD: begin
            rem_in = (DIV_W'(mag_ff[ci_ff][RED_W-1:0]) << (UNIT_F + 1)) +
                     DIV_W'(sqr_ff[LEN_W-1:0]);
            dsh_in = DIV_W'(sqr_ff[LEN_W-1:0]) << UNIT_W;
            q_in   = '0;
            j_in   = CNT_W'(UNIT_W - 1);
         end
         ST_DIV: begin
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = q_ff | (UNIT_W'(1) << j_ff);
            end
            dsh_in = dsh_ff >> 1;
            j_in   = j_ff - CNT_W'(1);
         end
         ST_DIVST: begin
            t_in[ci_ff] = neg_ff[ci_ff] ? -$signed(q_ff) : $signed(q_ff);
            ci_in       = (ci_ff == 2'd2) ? 2'd0 : ci_ff + 2'd1;
         end
         // Gram-Schmidt: dot product with the normal, then subtraction.
         ST_DOT: begin
            mac_ctrl.en       = 1'b1;
            mac_ctrl.from_acc = (ci_ff != 2'd0);
            mac_a             = MUL_W'(n_ff[ci_ff]);
            mac_b             = MUL_W'(t_ff[ci_ff]);
            ci_in             = (ci_ff == 2'd2) ? 2'd0 : ci_ff + 2'd1;
         end
         ST_RND: begin
            dr_in = acc[ACC_W-1] ? -DR_W'(rnd_q) : DR_W'(rnd_q);
         end
         ST_GS0: begin
            mac_ctrl.en        = 1'b1;
            mac_ctrl.from_base = 1'b1;
            mac_ctrl.sub       = 1'b1;
            mac_base           = ACC_W'(t_ff[ci_ff]) <<< UNIT_F;
            mac_a              = MUL_W'(n_ff[ci_ff]);
            mac_b              = MUL_W'(dr_ff);
         end
         ST_GS1: begin
            vec_in[ci_ff] = acc;
            ci_in         = (ci_ff == 2'd2) ? 2'd0 : ci_ff + 2'd1;
            if (ci_ff == 2'd2) begin
               pass_in = 1'b1;
            end
         end
         ST_OUT: begin
            if (load) begin
               rsp_in.tangent_x     = degen_ff ? '0 : t_ff[0];
               rsp_in.tangent_y     = degen_ff ? '0 : t_ff[1];
               rsp_in.tangent_z     = degen_ff ? '0 : t_ff[2];
               rsp_in.degenerate    = degen_ff;
               rsp_in.last_triangle = last_ff;
               rsp_valid_in         = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      ci_ff     <= ci_in;
      pass_ff   <= pass_in;
      p0_ff     <= p0_in;
      p1_ff     <= p1_in;
      uv0_ff    <= uv0_in;
      uv1_ff    <= uv1_in;
      n_ff      <= n_in;
      e1_ff     <= e1_in;
      e2_ff     <= e2_in;
      du1_ff    <= du1_in;
      dv1_ff    <= dv1_in;
      du2_ff    <= du2_in;
      dv2_ff    <= dv2_in;
      vec_ff    <= vec_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      t_ff      <= t_in;
      detneg_ff <= detneg_in;
      last_ff   <= last_in;
      degen_ff  <= degen_in;
      sqv_ff    <= sqv_in;
      sqr_ff    <= sqr_in;
      sqb_ff    <= sqb_in;
      rem_ff    <= rem_in;
      dsh_ff    <= dsh_in;
      q_ff      <= q_in;
      j_ff      <= j_in;
      dr_ff     <= dr_in;
      rsp_ff    <= rsp_in;
   end

   // A new result appears only from the output step.
   `TTG_ASSERT_NOW(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff == ST_OUT))
   // A degenerate triangle always carries a zero tangent.
   `TTG_ASSERT_NOW(a_degen_zero, rsp_valid_ff && rsp_ff.degenerate,
                   rsp_ff.tangent_x == '0 && rsp_ff.tangent_y == '0 && rsp_ff.tangent_z == '0)
   // The completing vertex starts the determinant.
   `TTG_ASSERT_NEXT(a_third_starts, accept && phase_ff == 2'd2, state_ff == ST_DET0)

endmodule
